/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion helpers for clocked properties with synchronous reset.
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/dsha_pkg.sv */
`timescale 1ns / 1ps
package dsha_pkg;
   typedef logic [31:0] word_type;
   typedef word_type [7:0] hash_type;
   typedef word_type [15:0] sched_type;

   typedef enum logic [2:0] {
      REG_MID01 = 3'd0, REG_MID23 = 3'd1, REG_MID45 = 3'd2, REG_MID67 = 3'd3,
      REG_TAIL0 = 3'd4, REG_TAIL8 = 3'd5, REG_TARGET = 3'd6, REG_MODE = 3'd7
   } reg_index_type;

   localparam int CSR_INDEX_W = 4;
   localparam int ROUNDS = 64;
   localparam word_type PAD_WORD = 32'h80000000;
   localparam word_type LEN_FIRST = 32'd640;
   localparam word_type LEN_SECOND = 32'd256;

   localparam hash_type IV = '{32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam word_type RK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type bswap(input word_type x);
      bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction
endpackage

/* src/dsha_stream_if.sv */
`timescale 1ns / 1ps
interface dsha_stream_if #(parameter int WIDTH = 32);
   logic valid;
   logic ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* src/dsha_round.sv */
`timescale 1ns / 1ps
module dsha_round import dsha_pkg::*; #(
   parameter int ROUND = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      valid_in,
   input  hash_type  state_in,
   input  sched_type sched_in,
   input  hash_type  base_in,
   output logic      valid_out,
   output hash_type  state_out,
   output sched_type sched_out,
   output hash_type  base_out
);
   logic      valid_ff;
   hash_type  state_ff, state_in_w;
   sched_type sched_ff, sched_in_w;
   hash_type  base_ff;
   word_type  t1, t2, a, e, nw;

   always_comb begin
      a = state_in[0];
      e = state_in[4];
      t1 = state_in[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
         + ((e & state_in[5]) ^ (~e & state_in[6])) + RK[ROUND] + sched_in[0];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
         + ((a & state_in[1]) ^ (a & state_in[2]) ^ (state_in[1] & state_in[2]));
      state_in_w = {state_in[6:4], state_in[3] + t1, state_in[2:0], t1 + t2};
      nw = sched_in[0] + (rotr(sched_in[1], 7) ^ rotr(sched_in[1], 18) ^ (sched_in[1] >> 3))
         + sched_in[9]
         + (rotr(sched_in[14], 17) ^ rotr(sched_in[14], 19) ^ (sched_in[14] >> 10));
      sched_in_w = {nw, sched_in[15:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         state_ff <= state_in_w;
         sched_ff <= sched_in_w;
         base_ff <= base_in;
      end
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign sched_out = sched_ff;
   assign base_out = base_ff;
endmodule

/* src/dsha_compress.sv */
`timescale 1ns / 1ps
module dsha_compress import dsha_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      valid_in,
   input  hash_type  init_in,
   input  sched_type msg_in,
   output logic      valid_out,
   output hash_type  hash_out
);
   logic      v [ROUNDS+1];
   hash_type  st [ROUNDS+1];
   sched_type sc [ROUNDS+1];
   hash_type  bs [ROUNDS+1];
   logic      valid_ff;
   hash_type  hash_ff, hash_in;

   assign v[0] = valid_in;
   assign st[0] = init_in;
   assign sc[0] = msg_in;
   assign bs[0] = init_in;

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      dsha_round #(.ROUND(r)) u_round (
         .clock(clock), .reset(reset), .advance(advance),
         .valid_in(v[r]), .state_in(st[r]), .sched_in(sc[r]), .base_in(bs[r]),
         .valid_out(v[r+1]), .state_out(st[r+1]), .sched_out(sc[r+1]), .base_out(bs[r+1])
      );
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         hash_in[i] = bs[ROUNDS][i] + st[ROUNDS][i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= v[ROUNDS];
      end
      if (advance) begin
         hash_ff <= hash_in;
      end
   end

   assign valid_out = valid_ff;
   assign hash_out = hash_ff;
endmodule

/* src/double_sha256_nonce_hasher_top.sv */
// Channel | Direction | Payload
// req     | in        | nonce (32)
// rsp     | out       | hit, top_word, digest_w01..digest_w67
// csr     | in        | write enable, index (4), data (64)
// One nonce is taken every cycle while the output is not stalled.
// A nonce passes through two 64-stage round pipelines, each with a final add stage,
// and one output register for the check.
// Reset is synchronous and clears all valid bits and configuration.
// When the output waits, the whole pipeline holds and nothing is lost.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module double_sha256_nonce_hasher_top import dsha_pkg::*; (
   input  logic clock,
   input  logic reset,
   dsha_stream_if.sink   req,
   dsha_stream_if.source rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_wdata
);
   logic [63:0] mid01_ff, mid23_ff, mid45_ff, mid67_ff, tail0_ff;
   logic [31:0] tail8_ff, target_ff;
   logic        mode_ff;
   logic        advance, v1, v2, rsp_valid_ff;
   hash_type    mid, h1, h2;
   sched_type   msg1, msg2;
   logic        hit_in;
   logic [288:0] rsp_data_ff, rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid01_ff <= '0; mid23_ff <= '0; mid45_ff <= '0; mid67_ff <= '0;
         tail0_ff <= '0; tail8_ff <= '0; target_ff <= '0; mode_ff <= 1'b0;
      end else if (csr_we && csr_index[3] == 1'b0) begin
         case (reg_index_type'(csr_index[2:0]))
            REG_MID01:  mid01_ff <= csr_wdata;
            REG_MID23:  mid23_ff <= csr_wdata;
            REG_MID45:  mid45_ff <= csr_wdata;
            REG_MID67:  mid67_ff <= csr_wdata;
            REG_TAIL0:  tail0_ff <= csr_wdata;
            REG_TAIL8:  tail8_ff <= csr_wdata[31:0];
            REG_TARGET: target_ff <= csr_wdata[31:0];
            REG_MODE:   mode_ff <= csr_wdata[0];
            default:    mode_ff <= mode_ff;
         endcase
      end
   end

   assign advance = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      mid = {mid67_ff[31:0], mid67_ff[63:32], mid45_ff[31:0], mid45_ff[63:32],
             mid23_ff[31:0], mid23_ff[63:32], mid01_ff[31:0], mid01_ff[63:32]};
      msg1 = '0;
      msg1[0] = tail0_ff[63:32];
      msg1[1] = tail0_ff[31:0];
      msg1[2] = tail8_ff;
      msg1[3] = bswap(req.data);
      msg1[4] = PAD_WORD;
      msg1[15] = LEN_FIRST;
      msg2 = '0;
      for (int i = 0; i < 8; i++) begin
         msg2[i] = h1[i];
      end
      msg2[8] = PAD_WORD;
      msg2[15] = LEN_SECOND;
   end

   dsha_compress u_first (
      .clock(clock), .reset(reset), .advance(advance), .valid_in(req.valid),
      .init_in(mid), .msg_in(msg1), .valid_out(v1), .hash_out(h1)
   );

   dsha_compress u_second (
      .clock(clock), .reset(reset), .advance(advance), .valid_in(v1),
      .init_in(IV), .msg_in(msg2), .valid_out(v2), .hash_out(h2)
   );

   always_comb begin
      hit_in = mode_ff ? (h2[7][15:0] == 16'd0) : (h2[7] <= target_ff);
      rsp_data_in = {hit_in, h2[7],
         hit_in ? {h2[0], h2[1]} : 64'd0, hit_in ? {h2[2], h2[3]} : 64'd0,
         hit_in ? {h2[4], h2[5]} : 64'd0, hit_in ? {h2[6], h2[7]} : 64'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v2;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_data_ff;

   `ASSERT_IMPLIES(a_ready_stall, clock, reset, rsp_valid_ff && !rsp.ready, !req.ready)
   `ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid_ff && !rsp.ready, rsp_valid_ff && $stable(rsp_data_ff))
   `ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_valid_ff && !rsp_data_ff[288], rsp_data_ff[255:0] == 256'd0)
endmodule

/* sim/tb_double_sha256_nonce_hasher_top.sv */
`timescale 1ns / 1ps
module tb_double_sha256_nonce_hasher_top;
   import dsha_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int PIPE_CYCLES = 140;
   localparam int CYCLE_LIMIT = 400000;
   localparam int UNUSED_INDEX = 8;
   localparam int PHASES = 10;
   localparam int ITEMS_PER_PHASE = 150;
   localparam logic [1:0] HIT_ANY = 2'd2;

   typedef struct packed {
      logic          hit;
      word_type      top_word;
      logic [63:0]   digest_w01;
      logic [63:0]   digest_w23;
      logic [63:0]   digest_w45;
      logic [63:0]   digest_w67;
   } verdict_type;

   typedef struct {
      verdict_type v;
      logic [1:0]  want_hit;
   } pending_type;

   typedef struct {
      word_type   target;
      logic       mode;
      word_type   nonce;
      logic [1:0] want_hit;
   } row_type;

   typedef word_type block_type [16];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   dsha_stream_if #(.WIDTH(32)) req ();
   dsha_stream_if #(.WIDTH($bits(verdict_type))) rsp ();

   double_sha256_nonce_hasher_top i_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   logic [63:0] mid_w01 = '0, mid_w23 = '0, mid_w45 = '0, mid_w67 = '0, tail_hi = '0;
   word_type tail_lo = '0, target_limit = '0;
   logic mode_low16 = 1'b0;

   pending_type hashes_due [$];
   int failures = 0;
   int results_seen = 0;
   int cycle_count = 0;
   logic [1:0] want_hit_now = HIT_ANY;

   always #HALF_PERIOD clock = ~clock;

   function automatic word_type ror(word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic hash_type sha_compress(hash_type h, block_type m);
      word_type w [64];
      word_type a, b, c, d, e, f, g, k, t1, t2;
      for (int i = 0; i < 16; i++) w[i] = m[i];
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
            + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; k = h[7];
      for (int i = 0; i < 64; i++) begin
         t1 = k + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + RK[i] + w[i];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         k = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d;
      h[4] += e; h[5] += f; h[6] += g; h[7] += k;
      return h;
   endfunction

   function automatic verdict_type hash_nonce(word_type nonce);
      hash_type h;
      block_type m;
      verdict_type v;
      logic hit;
      h[0] = mid_w01[63:32]; h[1] = mid_w01[31:0]; h[2] = mid_w23[63:32];
      h[3] = mid_w23[31:0];  h[4] = mid_w45[63:32]; h[5] = mid_w45[31:0];
      h[6] = mid_w67[63:32]; h[7] = mid_w67[31:0];
      for (int i = 0; i < 16; i++) m[i] = '0;
      m[0] = tail_hi[63:32];
      m[1] = tail_hi[31:0];
      m[2] = tail_lo;
      m[3] = {nonce[7:0], nonce[15:8], nonce[23:16], nonce[31:24]};
      m[4] = 32'h80000000;
      m[15] = 32'd640;
      h = sha_compress(h, m);
      for (int i = 0; i < 16; i++) m[i] = '0;
      for (int i = 0; i < 8; i++) m[i] = h[i];
      m[8] = 32'h80000000;
      m[15] = 32'd256;
      h = sha_compress(IV, m);
      hit = mode_low16 ? (h[7][15:0] == 16'h0) : (h[7] <= target_limit);
      v.hit = hit;
      v.top_word = h[7];
      v.digest_w01 = hit ? {h[0], h[1]} : '0;
      v.digest_w23 = hit ? {h[2], h[3]} : '0;
      v.digest_w45 = hit ? {h[4], h[5]} : '0;
      v.digest_w67 = hit ? {h[6], h[7]} : '0;
      return v;
   endfunction

   task automatic write_reg(int idx, logic [63:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx[CSR_INDEX_W-1:0];
      csr_wdata = value;
      case (idx)
         REG_MID01:  mid_w01 = value;
         REG_MID23:  mid_w23 = value;
         REG_MID45:  mid_w45 = value;
         REG_MID67:  mid_w67 = value;
         REG_TAIL0:  tail_hi = value;
         REG_TAIL8:  tail_lo = value[31:0];
         REG_TARGET: target_limit = value[31:0];
         REG_MODE:   mode_low16 = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_nonce(word_type nonce);
      @(negedge clock);
      req.valid = 1'b1;
      req.data = nonce;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic sender_gap(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req.valid = 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      sender_gap(1);
      while (hashes_due.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES) @(posedge clock);
   endtask

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         failures++;
         $display("%0t: %s mismatch expected %h actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      pending_type p;
      verdict_type got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
      if (!reset) begin
         if (req.valid && req.ready) begin
            p.v = hash_nonce(req.data);
            p.want_hit = want_hit_now;
            hashes_due.push_back(p);
         end
         if (rsp.valid && rsp.ready) begin
            got = rsp.data;
            results_seen++;
            if (hashes_due.size() == 0) begin
               failures++;
               $display("%0t: unexpected item expected none actual %h", $time, got);
            end else begin
               p = hashes_due.pop_front();
               if (p.want_hit != HIT_ANY) compare_field("hit (fixed)", p.want_hit[0], got.hit);
               compare_field("hit", p.v.hit, got.hit);
               compare_field("top_word", p.v.top_word, got.top_word);
               compare_field("digest_w01", p.v.digest_w01, got.digest_w01);
               compare_field("digest_w23", p.v.digest_w23, got.digest_w23);
               compare_field("digest_w45", p.v.digest_w45, got.digest_w45);
               compare_field("digest_w67", p.v.digest_w67, got.digest_w67);
            end
         end
      end
   end

   initial begin
      int hold_left;
      int stall_pct;
      bit held_once;
      hold_left = 0;
      stall_pct = 0;
      held_once = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if ((cycle_count % 64) == 0) begin
            case ($urandom_range(3))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 60;
               default: stall_pct = 90;
            endcase
         end
         if (!held_once && results_seen >= 469) begin
            held_once = 1;
            hold_left = 500;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready = 1'b0;
         end else begin
            rsp.ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   row_type rows [] = '{
      '{32'h0, 1'b0, 32'h00000000, HIT_ANY},
      '{32'h0, 1'b0, 32'hffffffff, HIT_ANY},
      '{32'h0, 1'b0, 32'h00000001, HIT_ANY},
      '{32'h0, 1'b0, 32'h80000000, HIT_ANY},
      '{32'h0, 1'b0, 32'h00ff00ff, HIT_ANY},
      '{32'h0, 1'b0, 32'h12345678, HIT_ANY},
      '{32'hffffffff, 1'b0, 32'h00000000, 2'd1},
      '{32'hffffffff, 1'b0, 32'hffffffff, 2'd1},
      '{32'hffffffff, 1'b0, 32'hdeadbeef, 2'd1},
      '{32'hffffffff, 1'b0, 32'h55aa55aa, 2'd1},
      '{32'h7fffffff, 1'b0, 32'h00000002, HIT_ANY},
      '{32'h7fffffff, 1'b0, 32'hfffffffe, HIT_ANY},
      '{32'h0, 1'b1, 32'h00000000, HIT_ANY},
      '{32'h0, 1'b1, 32'hffffffff, HIT_ANY},
      '{32'h0, 1'b1, 32'h0000ffff, HIT_ANY},
      '{32'h0, 1'b1, 32'hffff0000, HIT_ANY}
   };

   initial begin
      word_type cur_target;
      logic cur_mode;
      req.valid = 1'b0;
      req.data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      cur_target = '0;
      cur_mode = 1'b0;
      foreach (rows[i]) begin
         if (rows[i].target != cur_target || rows[i].mode != cur_mode) begin
            drain();
            write_reg(REG_TARGET, {32'h0, rows[i].target});
            write_reg(REG_MODE, {63'h0, rows[i].mode});
            cur_target = rows[i].target;
            cur_mode = rows[i].mode;
         end
         want_hit_now = rows[i].want_hit;
         send_nonce(rows[i].nonce);
      end
      drain();
      want_hit_now = HIT_ANY;
      // Excess bits are dropped and writes past the register list are ignored.
      write_reg(REG_MID01, 64'hffffffffffffffff);
      write_reg(REG_MID23, 64'hffffffffffffffff);
      write_reg(REG_MID45, 64'hffffffffffffffff);
      write_reg(REG_MID67, 64'hffffffffffffffff);
      write_reg(REG_TAIL0, 64'hffffffffffffffff);
      write_reg(REG_TAIL8, 64'hffffffffffffffff);
      write_reg(REG_TARGET, 64'hffffffff80000000);
      write_reg(REG_MODE, 64'hfffffffffffffffe);
      write_reg(UNUSED_INDEX, 64'h0123456789abcdef);
      write_reg(UNUSED_INDEX + 7, 64'hffffffffffffffff);
      send_nonce(32'h00000000);
      send_nonce(32'hffffffff);
      send_nonce(32'ha5a5a5a5);
      drain();
      for (int p = 0; p < PHASES; p++) begin
         if (p == 1) begin
            for (int r = REG_MID01; r <= REG_TAIL8; r++) write_reg(r, 64'h0);
         end else begin
            for (int r = REG_MID01; r <= REG_TAIL8; r++)
               write_reg(r, {$urandom, $urandom});
         end
         case (p % 4)
            0: write_reg(REG_TARGET, {$urandom, $urandom});
            1: write_reg(REG_TARGET, 64'h0);
            2: write_reg(REG_TARGET, 64'hffffffff);
            default: write_reg(REG_TARGET, {32'h0, 32'h0000ffff});
         endcase
         write_reg(REG_MODE, (p % 3 == 2) ? 64'h1 : 64'h0);
         if ($urandom_range(1)) write_reg($urandom_range(15, UNUSED_INDEX), {$urandom, $urandom});
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_nonce((n % 16 == 15) ? {16'h0, 16'($urandom_range(65535))} : $urandom);
            if ($urandom_range(5) == 0 && p % 4 != 3) sender_gap($urandom_range(1, 12));
         end
         drain();
      end
      if (failures == 0 && hashes_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
